// ===== rtl/core/multi_channel_frame_sync_assert.svh =====
// Assertion macros shared by the frame sync RTL.
`ifndef MULTI_CHANNEL_FRAME_SYNC_ASSERT_SVH
`define MULTI_CHANNEL_FRAME_SYNC_ASSERT_SVH

`ifndef SYNTHESIS
`define MCFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MCFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MCFS_ASSERT(lbl, prop, msg)
`define MCFS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/mcfs_pkg.sv =====
// Shared types and constants of the multi-channel frame sync.
package mcfs_pkg;

  localparam int CH_W      = 2;           // channel field width
  localparam int CH_SLOTS  = 1 << CH_W;   // channel numbers the field can carry
  localparam int TAG_OUT_W = 32;          // tag field width on both streams
  localparam int S_TDATA_W = 40;          // channel + tag, padded to bytes
  localparam int M_TDATA_W = 40;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CHANNELS = 1'b0,
    CFG_PACKAGE_MODE = 1'b1
  } cfg_idx_e;

  // Group of results released by one input beat.
  typedef struct packed {
    logic [CH_SLOTS-1:0] mask;      // channels that send, lowest first
    logic                packaged;
  } emit_ctl_t;

endpackage

// ===== rtl/core/mcfs_chan_queue.sv =====
// Per-channel tag queue: push with drop-oldest, then optional pop, in one pass.
`include "multi_channel_frame_sync_assert.svh"
module mcfs_chan_queue import mcfs_pkg::*; #(
  parameter int QUEUE_DEPTH = 2,
  parameter int TAG_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic                pop_i,
  output logic                has_data_o,  // after this cycle's push
  output logic [TAG_BITS-1:0] pop_tag_o
);

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(2 * QUEUE_DEPTH);

  logic [TAG_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [HW-1:0]       head_q, head_d, head_p, wslot;
  logic [FW-1:0]       fill_q, fill_d, fill_p;
  logic [SW-1:0]       slot_sum;
  logic                full;

  function automatic logic [HW-1:0] wrap_inc(input logic [HW-1:0] h);
    wrap_inc = (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + HW'(1);
  endfunction

  always_comb begin
    full     = (fill_q == FW'(QUEUE_DEPTH));
    slot_sum = SW'(head_q) + SW'(fill_q);
    wslot    = (slot_sum >= SW'(QUEUE_DEPTH)) ? HW'(slot_sum - SW'(QUEUE_DEPTH))
                                               : HW'(slot_sum);
    // a full queue drops its oldest tag before the push
    head_p   = (push_i && full) ? wrap_inc(head_q) : head_q;
    fill_p   = (push_i && !full) ? fill_q + FW'(1) : fill_q;
    // oldest tag may be the one arriving now
    pop_tag_o  = (push_i && (wslot == head_p)) ? tag_i : mem_q[head_p];
    has_data_o = (fill_p != '0);
    head_d     = pop_i ? wrap_inc(head_p) : head_p;
    fill_d     = pop_i ? fill_p - FW'(1) : fill_p;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wslot] <= tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  `MCFS_ASSERT(a_fill_bound, fill_q <= FW'(QUEUE_DEPTH), "queue fill exceeds depth")
  `MCFS_ASSERT_IMPL(a_pop_has_data, pop_i, has_data_o, "pop from empty queue")

endmodule

// ===== rtl/core/mcfs_out_buf.sv =====
// Result buffer: holds one input's release group and drains it a beat per cycle while m_axis_tready is high.
`include "multi_channel_frame_sync_assert.svh"
module mcfs_out_buf import mcfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  emit_ctl_t            ctl_i,
  input  logic [TAG_OUT_W-1:0] tags_i [CH_SLOTS],
  output logic                 empty_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [1:0] sent_channel, [33:2] sent_tag
  output logic                 m_axis_tuser,  // [0] packaged
  output logic                 m_axis_tlast
);

  logic [CH_SLOTS-1:0]  pend_q, pend_d, pick_oh;
  logic [TAG_OUT_W-1:0] tag_q [CH_SLOTS];
  logic                 pk_q;
  logic [CH_W-1:0]      pick_idx;
  logic                 move;

  logic                 ovld_q;
  logic [CH_W-1:0]      och_q;
  logic [TAG_OUT_W-1:0] otag_q;
  logic                 opk_q, olast_q;

  always_comb begin
    pick_idx = '0;
    for (int i = CH_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        pick_idx = CH_W'(i);
      end
    end
    pick_oh = CH_SLOTS'(1) << pick_idx;
    move    = (pend_q != '0) && (!ovld_q || m_axis_tready);
    pend_d  = load_i ? ctl_i.mask : (move ? (pend_q & ~pick_oh) : pend_q);
  end

  assign empty_o = (pend_q == '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tag_q <= tags_i;
      pk_q  <= ctl_i.packaged;
    end
    if (move) begin
      och_q   <= pick_idx;
      otag_q  <= tag_q[pick_idx];
      opk_q   <= pk_q;
      olast_q <= ((pend_q & ~pick_oh) == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (move) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {(M_TDATA_W - TAG_OUT_W - CH_W)'(0), otag_q, och_q};
  assign m_axis_tuser  = opk_q;
  assign m_axis_tlast  = olast_q;

  `MCFS_ASSERT_IMPL(a_load_when_empty, load_i, pend_q == '0, "group loaded over pending beats")

endmodule

// ===== rtl/core/multi_channel_frame_sync.sv =====
// A result beat passes the input register, the buffer's pending group and output register.
// An input beat releases 0 to 4 results; the result buffer drains one beat a cycle while
//   m_axis_tready is high, and the input register holds its beat until the buffer is empty.
// Reset (rst_ni low, async): queues empty, all send permits set, 4 channels, single mode.
// Queue contents are not cleared; only written slots are ever read.
`include "multi_channel_frame_sync_assert.svh"
module multi_channel_frame_sync import mcfs_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int QUEUE_DEPTH  = 2,
  parameter int TAG_BITS     = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_wr_en_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [1:0] source_channel, [33:2] frame_tag
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [1:0] sent_channel, [33:2] sent_tag
  output logic                 m_axis_tuser,   // [0] packaged
  output logic                 m_axis_tlast    // last
);

  localparam int WW = (TAG_BITS > TAG_OUT_W) ? TAG_BITS : TAG_OUT_W;

  // config registers
  logic [CFG_DAT_W-1:0] cfg_num_q;
  logic                 cfg_pkg_q;

  // input register
  logic                 in_vld_q;
  logic [CH_W-1:0]      in_ch_q;
  logic [TAG_OUT_W-1:0] in_tag_q;

  logic                 go, valid_in, buf_empty;
  logic [CFG_DAT_W-1:0] nch;
  logic [WW-1:0]        in_wide;
  logic [TAG_BITS-1:0]  q_tag;

  logic [CH_SLOTS-1:0]  act, has, push_en, pop_en, emit, per_act;
  logic [CH_SLOTS-1:0]  permit_q, permit_d;
  logic                 any_permit, all_have;
  logic [TAG_BITS-1:0]  pop_tag [CH_SLOTS];
  logic [TAG_OUT_W-1:0] out_tag [CH_SLOTS];
  emit_ctl_t            ctl;

  // Input beat sits in in_*_q; it is processed once the result buffer is free.
  assign go            = in_vld_q && buf_empty;
  assign s_axis_tready = !in_vld_q || go;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q  <= s_axis_tdata[CH_W-1:0];
      in_tag_q <= s_axis_tdata[CH_W +: TAG_OUT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      cfg_num_q <= CFG_DAT_W'(4);
      cfg_pkg_q <= 1'b0;
      permit_q  <= '1;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (cfg_wr_en_i) begin
        case (cfg_idx_i)
          CFG_NUM_CHANNELS: cfg_num_q <= cfg_wdata_i;
          CFG_PACKAGE_MODE: cfg_pkg_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      permit_q <= permit_d;
    end
  end

  // Effective channel count: zero acts as one, clamp at MAX_CHANNELS.
  always_comb begin
    if (cfg_num_q == '0) begin
      nch = CFG_DAT_W'(1);
    end else if (cfg_num_q > CFG_DAT_W'(MAX_CHANNELS)) begin
      nch = CFG_DAT_W'(MAX_CHANNELS);
    end else begin
      nch = cfg_num_q;
    end
  end

  assign valid_in = (CFG_DAT_W'(in_ch_q) < nch);
  assign in_wide  = WW'(in_tag_q);
  assign q_tag    = in_wide[TAG_BITS-1:0];

  // Per-channel queues; channel numbers from MAX_CHANNELS up have none.
  for (genvar c = 0; c < CH_SLOTS; c++) begin : g_ch
    logic [WW-1:0] pop_wide;
    assign act[c]     = (CFG_DAT_W'(c) < nch);
    assign push_en[c] = go && valid_in && (in_ch_q == CH_W'(c));
    assign pop_en[c]  = go && valid_in && emit[c];
    assign pop_wide   = WW'(pop_tag[c]);
    assign out_tag[c] = pop_wide[TAG_OUT_W-1:0];
    if (c < MAX_CHANNELS) begin : g_q
      mcfs_chan_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
      ) u_queue (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .push_i     (push_en[c]),
        .tag_i      (q_tag),
        .pop_i      (pop_en[c]),
        .has_data_o (has[c]),
        .pop_tag_o  (pop_tag[c])
      );
    end else begin : g_none
      assign has[c]     = 1'b0;
      assign pop_tag[c] = '0;
    end
  end

  // Release decision.
  // Single mode: permitted channels with data send; with no permit left among the
  //   active channels, a new round starts and every active channel with data sends.
  // Package mode: one tag from each active channel once all of them hold one.
  always_comb begin
    per_act    = permit_q & act;
    any_permit = |per_act;
    all_have   = &(has | ~act);
    permit_d   = permit_q;
    if (cfg_pkg_q) begin
      emit = all_have ? act : '0;
    end else if (any_permit) begin
      emit = per_act & has & act;
      if (go && valid_in) begin
        permit_d = permit_q & ~emit;
      end
    end else begin
      emit = has & act;
      if (go && valid_in) begin
        permit_d = (permit_q & ~act) | (act & ~has);
      end
    end
    ctl.mask     = (go && valid_in) ? emit : '0;
    ctl.packaged = cfg_pkg_q;
  end

  mcfs_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (go),
    .ctl_i         (ctl),
    .tags_i        (out_tag),
    .empty_o       (buf_empty),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `MCFS_ASSERT_IMPL(a_pkg_group, go && valid_in && cfg_pkg_q, emit == '0 || emit == act, "partial package group")
  `MCFS_ASSERT_IMPL(a_emit_active, go, (ctl.mask & ~act) == '0, "inactive channel released")

endmodule
